// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file egm_chk.sv.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/egm_pkg.sv =====
// Shared types, codes and constants of the ElGamal engine.
// No dependencies; used by every module of the block.
package egm_pkg;

	localparam int VAL_W = 32;
	localparam int CNT_W = $clog2(VAL_W);

	localparam logic [1:0] FUNC_ENC  = 2'd0;
	localparam logic [1:0] FUNC_DEC  = 2'd1;
	localparam logic [1:0] FUNC_SIGN = 2'd2;
	localparam logic [1:0] FUNC_VER  = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_NONCE = 2'd1;
	localparam logic [1:0] STATUS_NO_INV    = 2'd2;

	localparam logic [1:0] CFG_MODULUS   = 2'd0;
	localparam logic [1:0] CFG_GENERATOR = 2'd1;
	localparam logic [1:0] CFG_PRIV_KEY  = 2'd2;
	localparam logic [1:0] CFG_PUB_KEY   = 2'd3;

	localparam logic [VAL_W-1:0] RST_MODULUS   = 32'd4294967291;
	localparam logic [VAL_W-1:0] RST_GENERATOR = 32'd2;
	localparam logic [VAL_W-1:0] RST_PRIV_KEY  = 32'd1;
	localparam logic [VAL_W-1:0] RST_PUB_KEY   = 32'd0;

	typedef enum logic {ALU_MUL, ALU_DIV} egm_alu_op_t;

	typedef struct packed {
		logic        start;
		egm_alu_op_t op;
	} egm_alu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STEP, ST_WAIT, ST_POW_RED, ST_POW_LOOP, ST_POW_MUL, ST_POW_SQR,
		ST_INV_RED, ST_INV_LOOP, ST_INV_DIV, ST_INV_MUL, ST_DONE
	} egm_state_t;

	typedef enum logic [2:0] {K_MOD, K_MUL, K_POW, K_INV, K_SUB, K_END} egm_kind_t;

	typedef enum logic [3:0] {
		SRC_MSG, SRC_FC, SRC_SC, SRC_NONCE, SRC_G, SRC_H, SRC_X,
		SRC_R0, SRC_R1, SRC_R2, SRC_R3
	} egm_src_t;

	typedef struct packed {
		egm_kind_t  kind;
		egm_src_t   asel;
		egm_src_t   bsel;
		logic       qmod;
		logic [1:0] dst;
	} egm_uop_t;

	typedef struct packed {
		logic [VAL_W-1:0] first;
		logic [VAL_W-1:0] second;
		logic             ver;
		logic [1:0]       st;
	} egm_result_t;

	function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b, input logic [VAL_W-1:0] m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

endpackage

// ===== rtl/core/egm_alu.sv =====
// Shared bit-serial unit: modular multiply (shift-add) and restoring divide.
// Depends on egm_pkg.
module egm_alu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  egm_pkg::egm_alu_req_t        req,
	input  logic [egm_pkg::VAL_W-1:0]    a,
	input  logic [egm_pkg::VAL_W-1:0]    b,
	input  logic [egm_pkg::VAL_W-1:0]    m,
	output logic                         done,
	output logic [egm_pkg::VAL_W-1:0]    res,
	output logic [egm_pkg::VAL_W-1:0]    quo
);

	localparam int W = egm_pkg::VAL_W;

	logic                      busy_q, done_q;
	egm_pkg::egm_alu_op_t      op_q;
	logic [egm_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]              a_q, b_q, m_q, acc_q, quo_q;
	logic [W:0]                dbl, dblr, sum, sumr, rem, remn;
	logic                      ge;
	logic [W-1:0]              acc_nx;

	always_comb begin
		dbl  = {acc_q, 1'b0};
		dblr = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum  = dblr + (b_q[W-1] ? {1'b0, a_q} : '0);
		sumr = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		rem  = {acc_q, a_q[W-1]};
		ge   = (rem >= {1'b0, m_q});
		remn = ge ? rem - {1'b0, m_q} : rem;
		acc_nx = (op_q == egm_pkg::ALU_MUL) ? sumr[W-1:0] : remn[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= egm_pkg::CNT_W'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			b_q   <= {b_q[W-2:0], 1'b0};
			if (op_q == egm_pkg::ALU_DIV) begin
				a_q   <= {a_q[W-2:0], 1'b0};
				quo_q <= {quo_q[W-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/egm_seq.sv =====
// Sequencer: runs each operation as steps of reduce, multiply, power and inverse
// on the shared unit, and of subtract outside it. Depends on egm_pkg; drives egm_alu.
module egm_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_acc,
	input  logic [1:0]                func,
	input  logic [egm_pkg::VAL_W-1:0] message,
	input  logic [egm_pkg::VAL_W-1:0] first_cipher,
	input  logic [egm_pkg::VAL_W-1:0] second_cipher,
	input  logic [egm_pkg::VAL_W-1:0] nonce,
	input  logic [egm_pkg::VAL_W-1:0] p,
	input  logic [egm_pkg::VAL_W-1:0] g,
	input  logic [egm_pkg::VAL_W-1:0] x,
	input  logic [egm_pkg::VAL_W-1:0] h,
	output logic                      idle,
	output logic                      res_valid,
	input  logic                      res_take,
	output egm_pkg::egm_result_t      res,
	output egm_pkg::egm_alu_req_t     alu_req,
	output logic [egm_pkg::VAL_W-1:0] alu_a,
	output logic [egm_pkg::VAL_W-1:0] alu_b,
	output logic [egm_pkg::VAL_W-1:0] alu_m,
	input  logic                      alu_done,
	input  logic [egm_pkg::VAL_W-1:0] alu_res,
	input  logic [egm_pkg::VAL_W-1:0] alu_quo
);

	localparam int W = egm_pkg::VAL_W;
	localparam logic [W-1:0] ONE = W'(1);

	egm_pkg::egm_state_t  state_q, state_d;
	logic [1:0]           func_q, func_d;
	logic [W-1:0]         msg_q, msg_d, fc_q, fc_d, sc_q, sc_d, nonce_q, nonce_d;
	logic [3:0]           step_q, step_d;
	logic [W-1:0]         r0_q, r1_q, r2_q, r3_q;
	logic                 qmod_q, qmod_d;
	logic [1:0]           dst_q, dst_d;
	logic [W-1:0]         pb_q, pb_d, pacc_q, pacc_d, pe_q, pe_d;
	logic [W-1:0]         ir0_q, ir0_d, ir1_q, ir1_d, it0_q, it0_d, it1_q, it1_d;
	egm_pkg::egm_result_t res_q, fin_val;
	logic                 fin_en;
	logic                 wb_en;
	logic [1:0]           wb_dst;
	logic [W-1:0]         wb_val;
	egm_pkg::egm_uop_t    uc;
	logic                 modsel;
	logic [W-1:0]         modv, a_val, b_val, one_m;
	egm_pkg::egm_result_t end_val;

	function automatic egm_pkg::egm_uop_t decode(input logic [1:0] f, input logic [3:0] s);
		egm_pkg::egm_uop_t u;
		u = '{kind: egm_pkg::K_END, asel: egm_pkg::SRC_MSG, bsel: egm_pkg::SRC_MSG,
			qmod: 1'b0, dst: 2'd0};
		unique case (f)
			egm_pkg::FUNC_ENC: begin
				unique case (s)
					4'd0: u = '{egm_pkg::K_MOD, egm_pkg::SRC_MSG, egm_pkg::SRC_MSG, 1'b0, 2'd0};
					4'd1: u = '{egm_pkg::K_POW, egm_pkg::SRC_H, egm_pkg::SRC_NONCE, 1'b0, 2'd1};
					4'd2: u = '{egm_pkg::K_POW, egm_pkg::SRC_G, egm_pkg::SRC_NONCE, 1'b0, 2'd2};
					4'd3: u = '{egm_pkg::K_MUL, egm_pkg::SRC_R0, egm_pkg::SRC_R1, 1'b0, 2'd3};
					default: ;
				endcase
			end
			egm_pkg::FUNC_DEC: begin
				unique case (s)
					4'd0: u = '{egm_pkg::K_MOD, egm_pkg::SRC_FC, egm_pkg::SRC_FC, 1'b0, 2'd0};
					4'd1: u = '{egm_pkg::K_POW, egm_pkg::SRC_R0, egm_pkg::SRC_X, 1'b0, 2'd1};
					4'd2: u = '{egm_pkg::K_INV, egm_pkg::SRC_R1, egm_pkg::SRC_R1, 1'b0, 2'd2};
					4'd3: u = '{egm_pkg::K_MOD, egm_pkg::SRC_SC, egm_pkg::SRC_SC, 1'b0, 2'd0};
					4'd4: u = '{egm_pkg::K_MUL, egm_pkg::SRC_R0, egm_pkg::SRC_R2, 1'b0, 2'd3};
					default: ;
				endcase
			end
			egm_pkg::FUNC_SIGN: begin
				unique case (s)
					4'd0: u = '{egm_pkg::K_INV, egm_pkg::SRC_NONCE, egm_pkg::SRC_NONCE, 1'b1, 2'd0};
					4'd1: u = '{egm_pkg::K_POW, egm_pkg::SRC_G, egm_pkg::SRC_NONCE, 1'b0, 2'd1};
					4'd2: u = '{egm_pkg::K_MOD, egm_pkg::SRC_X, egm_pkg::SRC_X, 1'b1, 2'd2};
					4'd3: u = '{egm_pkg::K_MOD, egm_pkg::SRC_R1, egm_pkg::SRC_R1, 1'b1, 2'd3};
					4'd4: u = '{egm_pkg::K_MUL, egm_pkg::SRC_R2, egm_pkg::SRC_R3, 1'b1, 2'd2};
					4'd5: u = '{egm_pkg::K_MOD, egm_pkg::SRC_MSG, egm_pkg::SRC_MSG, 1'b1, 2'd3};
					4'd6: u = '{egm_pkg::K_SUB, egm_pkg::SRC_R3, egm_pkg::SRC_R2, 1'b1, 2'd3};
					4'd7: u = '{egm_pkg::K_MUL, egm_pkg::SRC_R0, egm_pkg::SRC_R3, 1'b1, 2'd3};
					default: ;
				endcase
			end
			egm_pkg::FUNC_VER: begin
				unique case (s)
					4'd0: u = '{egm_pkg::K_POW, egm_pkg::SRC_H, egm_pkg::SRC_FC, 1'b0, 2'd0};
					4'd1: u = '{egm_pkg::K_POW, egm_pkg::SRC_FC, egm_pkg::SRC_SC, 1'b0, 2'd1};
					4'd2: u = '{egm_pkg::K_MUL, egm_pkg::SRC_R0, egm_pkg::SRC_R1, 1'b0, 2'd2};
					4'd3: u = '{egm_pkg::K_POW, egm_pkg::SRC_G, egm_pkg::SRC_MSG, 1'b0, 2'd3};
					default: ;
				endcase
			end
		endcase
		return u;
	endfunction

	function automatic logic [W-1:0] srcval(input egm_pkg::egm_src_t sel,
		input logic [W-1:0] vm, input logic [W-1:0] vfc, input logic [W-1:0] vsc,
		input logic [W-1:0] vn, input logic [W-1:0] vg, input logic [W-1:0] vh,
		input logic [W-1:0] vx, input logic [W-1:0] v0, input logic [W-1:0] v1,
		input logic [W-1:0] v2, input logic [W-1:0] v3);
		logic [W-1:0] v;
		unique case (sel)
			egm_pkg::SRC_MSG:   v = vm;
			egm_pkg::SRC_FC:    v = vfc;
			egm_pkg::SRC_SC:    v = vsc;
			egm_pkg::SRC_NONCE: v = vn;
			egm_pkg::SRC_G:     v = vg;
			egm_pkg::SRC_H:     v = vh;
			egm_pkg::SRC_X:     v = vx;
			egm_pkg::SRC_R0:    v = v0;
			egm_pkg::SRC_R1:    v = v1;
			egm_pkg::SRC_R2:    v = v2;
			egm_pkg::SRC_R3:    v = v3;
			default:            v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uc     = decode(func_q, step_q);
		modsel = (state_q == egm_pkg::ST_STEP) ? uc.qmod : qmod_q;
		modv   = modsel ? p - ONE : p;
		one_m  = (modv == ONE) ? '0 : ONE;
		a_val  = srcval(uc.asel, msg_q, fc_q, sc_q, nonce_q, g, h, x, r0_q, r1_q, r2_q, r3_q);
		b_val  = srcval(uc.bsel, msg_q, fc_q, sc_q, nonce_q, g, h, x, r0_q, r1_q, r2_q, r3_q);
		end_val = '0;
		unique case (func_q)
			egm_pkg::FUNC_ENC:  begin end_val.first = r2_q; end_val.second = r3_q; end
			egm_pkg::FUNC_DEC:  end_val.first = r3_q;
			egm_pkg::FUNC_SIGN: begin end_val.first = r1_q; end_val.second = r3_q; end
			egm_pkg::FUNC_VER:  end_val.ver = (r2_q == r3_q);
		endcase
	end

	always_comb begin
		state_d = state_q;
		func_d  = func_q;
		msg_d   = msg_q;
		fc_d    = fc_q;
		sc_d    = sc_q;
		nonce_d = nonce_q;
		step_d  = step_q;
		qmod_d  = qmod_q;
		dst_d   = dst_q;
		pb_d    = pb_q;
		pacc_d  = pacc_q;
		pe_d    = pe_q;
		ir0_d   = ir0_q;
		ir1_d   = ir1_q;
		it0_d   = it0_q;
		it1_d   = it1_q;
		fin_en  = 1'b0;
		fin_val = '0;
		wb_en   = 1'b0;
		wb_dst  = dst_q;
		wb_val  = alu_res;
		alu_req = '{start: 1'b0, op: egm_pkg::ALU_MUL};
		alu_a   = a_val;
		alu_b   = b_val;
		alu_m   = modv;
		unique case (state_q)
			egm_pkg::ST_IDLE: begin
				if (in_acc) begin
					func_d  = func;
					msg_d   = message;
					fc_d    = first_cipher;
					sc_d    = second_cipher;
					nonce_d = nonce;
					step_d  = '0;
					if (p < W'(2)) begin
						fin_en     = 1'b1;
						fin_val.st = egm_pkg::STATUS_NO_INV;
						state_d    = egm_pkg::ST_DONE;
					end else begin
						state_d = egm_pkg::ST_STEP;
					end
				end
			end
			egm_pkg::ST_STEP: begin
				qmod_d = uc.qmod;
				dst_d  = uc.dst;
				// out-of-range r on verify rejects without any arithmetic
				if (func_q == egm_pkg::FUNC_VER && step_q == '0 &&
					(fc_q == '0 || fc_q >= p)) begin
					fin_en  = 1'b1;
					state_d = egm_pkg::ST_DONE;
				end else begin
					unique case (uc.kind)
						egm_pkg::K_MOD: begin
							alu_req = '{start: 1'b1, op: egm_pkg::ALU_DIV};
							state_d = egm_pkg::ST_WAIT;
						end
						egm_pkg::K_MUL: begin
							alu_req = '{start: 1'b1, op: egm_pkg::ALU_MUL};
							state_d = egm_pkg::ST_WAIT;
						end
						egm_pkg::K_POW: begin
							alu_req = '{start: 1'b1, op: egm_pkg::ALU_DIV};
							pe_d    = b_val;
							state_d = egm_pkg::ST_POW_RED;
						end
						egm_pkg::K_INV: begin
							alu_req = '{start: 1'b1, op: egm_pkg::ALU_DIV};
							state_d = egm_pkg::ST_INV_RED;
						end
						egm_pkg::K_SUB: begin
							wb_en  = 1'b1;
							wb_dst = uc.dst;
							wb_val = egm_pkg::sub_mod(a_val, b_val, modv);
							step_d = step_q + 1'b1;
						end
						egm_pkg::K_END: begin
							fin_en  = 1'b1;
							fin_val = end_val;
							state_d = egm_pkg::ST_DONE;
						end
						default: state_d = egm_pkg::ST_IDLE;
					endcase
				end
			end
			egm_pkg::ST_WAIT: begin
				if (alu_done) begin
					// decrypt with c1 == 0 mod p has no inverse
					if (func_q == egm_pkg::FUNC_DEC && step_q == '0 && alu_res == '0) begin
						fin_en     = 1'b1;
						fin_val.st = egm_pkg::STATUS_NO_INV;
						state_d    = egm_pkg::ST_DONE;
					end else begin
						wb_en   = 1'b1;
						step_d  = step_q + 1'b1;
						state_d = egm_pkg::ST_STEP;
					end
				end
			end
			egm_pkg::ST_POW_RED: begin
				if (alu_done) begin
					pb_d    = alu_res;
					pacc_d  = one_m;
					state_d = egm_pkg::ST_POW_LOOP;
				end
			end
			egm_pkg::ST_POW_LOOP: begin
				alu_req.op = egm_pkg::ALU_MUL;
				if (pe_q == '0) begin
					wb_en   = 1'b1;
					wb_val  = pacc_q;
					step_d  = step_q + 1'b1;
					state_d = egm_pkg::ST_STEP;
				end else if (pe_q[0]) begin
					alu_req.start = 1'b1;
					alu_a   = pacc_q;
					alu_b   = pb_q;
					state_d = egm_pkg::ST_POW_MUL;
				end else begin
					alu_req.start = 1'b1;
					alu_a   = pb_q;
					alu_b   = pb_q;
					state_d = egm_pkg::ST_POW_SQR;
				end
			end
			egm_pkg::ST_POW_MUL: begin
				if (alu_done) begin
					pacc_d  = alu_res;
					alu_req = '{start: 1'b1, op: egm_pkg::ALU_MUL};
					alu_a   = pb_q;
					alu_b   = pb_q;
					state_d = egm_pkg::ST_POW_SQR;
				end
			end
			egm_pkg::ST_POW_SQR: begin
				if (alu_done) begin
					pb_d    = alu_res;
					pe_d    = pe_q >> 1;
					state_d = egm_pkg::ST_POW_LOOP;
				end
			end
			egm_pkg::ST_INV_RED: begin
				if (alu_done) begin
					ir0_d   = modv;
					ir1_d   = alu_res;
					it0_d   = '0;
					it1_d   = one_m;
					state_d = egm_pkg::ST_INV_LOOP;
				end
			end
			egm_pkg::ST_INV_LOOP: begin
				if (ir1_q == '0) begin
					if (ir0_q == ONE) begin
						wb_en   = 1'b1;
						wb_val  = it0_q;
						step_d  = step_q + 1'b1;
						state_d = egm_pkg::ST_STEP;
					end else begin
						fin_en     = 1'b1;
						fin_val.st = (func_q == egm_pkg::FUNC_SIGN) ?
							egm_pkg::STATUS_BAD_NONCE : egm_pkg::STATUS_NO_INV;
						state_d    = egm_pkg::ST_DONE;
					end
				end else begin
					alu_req = '{start: 1'b1, op: egm_pkg::ALU_DIV};
					alu_a   = ir0_q;
					alu_m   = ir1_q;
					state_d = egm_pkg::ST_INV_DIV;
				end
			end
			egm_pkg::ST_INV_DIV: begin
				if (alu_done) begin
					ir0_d   = ir1_q;
					ir1_d   = alu_res;
					// quotient never exceeds the modulus; equal means zero mod m
					alu_req = '{start: 1'b1, op: egm_pkg::ALU_MUL};
					alu_a   = (alu_quo == modv) ? '0 : alu_quo;
					alu_b   = it1_q;
					state_d = egm_pkg::ST_INV_MUL;
				end
			end
			egm_pkg::ST_INV_MUL: begin
				if (alu_done) begin
					it0_d   = it1_q;
					it1_d   = egm_pkg::sub_mod(it0_q, alu_res, modv);
					state_d = egm_pkg::ST_INV_LOOP;
				end
			end
			egm_pkg::ST_DONE: begin
				if (res_take) state_d = egm_pkg::ST_IDLE;
			end
			default: state_d = egm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		msg_q   <= msg_d;
		fc_q    <= fc_d;
		sc_q    <= sc_d;
		nonce_q <= nonce_d;
		step_q  <= step_d;
		qmod_q  <= qmod_d;
		dst_q   <= dst_d;
		pb_q    <= pb_d;
		pacc_q  <= pacc_d;
		pe_q    <= pe_d;
		ir0_q   <= ir0_d;
		ir1_q   <= ir1_d;
		it0_q   <= it0_d;
		it1_q   <= it1_d;
		if (fin_en) res_q <= fin_val;
		if (wb_en) begin
			unique case (wb_dst)
				2'd0: r0_q <= wb_val;
				2'd1: r1_q <= wb_val;
				2'd2: r2_q <= wb_val;
				2'd3: r3_q <= wb_val;
			endcase
		end
	end

	assign idle      = (state_q == egm_pkg::ST_IDLE);
	assign res_valid = (state_q == egm_pkg::ST_DONE);
	assign res       = res_q;

endmodule

// ===== rtl/core/elgamal_mod_prime_engine.sv =====
// ElGamal engine top: config registers, sequencer, shared unit, output register.
// Each unit operation is one bit-serial multiply or divide. A power reduces its base, then
//   squares once per exponent bit and multiplies once per set bit; an inverse reduces its
//   operand, then runs Euclid rounds of one divide and one multiply each.
// One item at a time: a new input is taken only while the sequencer is idle.
// Reset (arst_n low, asynchronous): idle, no result pending, registers p=4294967291,
//   g=2, x=1, h=0.
module elgamal_mod_prime_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [egm_pkg::VAL_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [egm_pkg::VAL_W-1:0] message,
	input  logic [egm_pkg::VAL_W-1:0] first_cipher,
	input  logic [egm_pkg::VAL_W-1:0] second_cipher,
	input  logic [egm_pkg::VAL_W-1:0] nonce,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [egm_pkg::VAL_W-1:0] result_first,
	output logic [egm_pkg::VAL_W-1:0] result_second,
	output logic                      verified,
	output logic [1:0]                status
);

	logic [egm_pkg::VAL_W-1:0] p_q, g_q, x_q, h_q;
	logic                      idle, in_acc, res_valid, res_take;
	egm_pkg::egm_result_t      res, out_q;
	logic                      out_valid_q;
	egm_pkg::egm_alu_req_t     alu_req;
	logic [egm_pkg::VAL_W-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;
	logic                      alu_done;

	// configuration writes: the user must make them only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= egm_pkg::RST_MODULUS;
			g_q <= egm_pkg::RST_GENERATOR;
			x_q <= egm_pkg::RST_PRIV_KEY;
			h_q <= egm_pkg::RST_PUB_KEY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				egm_pkg::CFG_MODULUS:   p_q <= cfg_data;
				egm_pkg::CFG_GENERATOR: g_q <= cfg_data;
				egm_pkg::CFG_PRIV_KEY:  x_q <= cfg_data;
				egm_pkg::CFG_PUB_KEY:   h_q <= cfg_data;
			endcase
		end
	end

	// input transfer only when the sequencer is idle
	assign in_stall = !idle;
	assign in_acc   = in_valid && !in_stall;

	egm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_acc        (in_acc),
		.func          (func),
		.message       (message),
		.first_cipher  (first_cipher),
		.second_cipher (second_cipher),
		.nonce         (nonce),
		.p             (p_q),
		.g             (g_q),
		.x             (x_q),
		.h             (h_q),
		.idle          (idle),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res),
		.alu_req       (alu_req),
		.alu_a         (alu_a),
		.alu_b         (alu_b),
		.alu_m         (alu_m),
		.alu_done      (alu_done),
		.alu_res       (alu_res),
		.alu_quo       (alu_quo)
	);

	egm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.m      (alu_m),
		.done   (alu_done),
		.res    (alu_res),
		.quo    (alu_quo)
	);

	// output register: the next item may start while a result waits here
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign result_first  = out_q.first;
	assign result_second = out_q.second;
	assign verified      = out_q.ver;
	assign status        = out_q.st;

endmodule

// ===== rtl/core/egm_chk.sv =====
// Port-level checker for the ElGamal engine, bound to the top level.
// Depends on egm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module egm_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [egm_pkg::VAL_W-1:0] result_first,
	input logic [egm_pkg::VAL_W-1:0] result_second,
	input logic                      verified,
	input logic [1:0]                status
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_first) && $stable(result_second) && $stable(status))
	// one item at a time: busy right after a transfer in
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	// any error status carries zero results and no verify pass
	`ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != egm_pkg::STATUS_OK, result_first == '0 && result_second == '0 && !verified)
	// a verify pass carries nothing else
	`ASSERT_IMP(a_ver_clean, clk, arst_n, out_valid && verified, status == egm_pkg::STATUS_OK && result_first == '0 && result_second == '0)

endmodule

bind elgamal_mod_prime_engine egm_chk u_egm_chk (.*);

// ===== test/testbench.sv =====
// Testbench for elgamal_mod_prime_engine: keys, encrypt/decrypt and sign/verify traffic.
// Depends on egm_pkg and the engine RTL; self-checking against a modular-arithmetic predictor.

// Expected-result store with its own copy of the key registers and the ElGamal arithmetic.
class elgamal_scoreboard;
	typedef longint unsigned u64_t;

	u64_t p_reg = egm_pkg::RST_MODULUS;
	u64_t g_reg = egm_pkg::RST_GENERATOR;
	u64_t x_reg = egm_pkg::RST_PRIV_KEY;
	u64_t h_reg = egm_pkg::RST_PUB_KEY;
	egm_pkg::egm_result_t expected_q[$];
	int mismatches;
	int results_seen;

	function void set_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			egm_pkg::CFG_MODULUS:   p_reg = val;
			egm_pkg::CFG_GENERATOR: g_reg = val;
			egm_pkg::CFG_PRIV_KEY:  x_reg = val;
			default:                h_reg = val;
		endcase
	endfunction

	function u64_t mulm(u64_t a, u64_t b, u64_t m);
		return ((a % m) * (b % m)) % m;
	endfunction

	function u64_t submod(u64_t a, u64_t b, u64_t m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function u64_t powm(u64_t b, u64_t e, u64_t m);
		u64_t acc;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				acc = mulm(acc, b, m);
			b = mulm(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Extended Euclid; ok clears when gcd(a, m) != 1.
	function u64_t invm(u64_t a, u64_t m, output bit ok);
		u64_t r0, r1, t0, t1, q, rn, tn;
		r0 = m;
		r1 = a % m;
		t0 = 0;
		t1 = 1 % m;
		while (r1 != 0) begin
			q = r0 / r1;
			rn = r0 - q * r1;
			tn = submod(t0, mulm(q % m, t1, m), m);
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		ok = (r0 == 1);
		return t0;
	endfunction

	function egm_pkg::egm_result_t predict(logic [1:0] fn, u64_t msg, u64_t fc, u64_t sc,
		u64_t k);
		egm_pkg::egm_result_t res;
		u64_t q, inv, r, xr, lhs;
		bit ok;
		res = '0;
		if (p_reg < 2) begin
			res.st = egm_pkg::STATUS_NO_INV;
		end else if (fn == egm_pkg::FUNC_ENC) begin
			res.first  = 32'(powm(g_reg, k, p_reg));
			res.second = 32'(mulm(msg, powm(h_reg, k, p_reg), p_reg));
		end else if (fn == egm_pkg::FUNC_DEC) begin
			inv = invm(powm(fc, x_reg, p_reg), p_reg, ok);
			if ((fc % p_reg) == 0 || !ok)
				res.st = egm_pkg::STATUS_NO_INV;
			else
				res.first = 32'(mulm(sc, inv, p_reg));
		end else if (fn == egm_pkg::FUNC_SIGN) begin
			q = p_reg - 1;
			inv = invm(k, q, ok);
			if (!ok) begin
				res.st = egm_pkg::STATUS_BAD_NONCE;
			end else begin
				r = powm(g_reg, k, p_reg);
				xr = mulm(x_reg, r, q);
				res.first  = 32'(r);
				res.second = 32'(mulm(inv, submod(msg % q, xr, q), q));
			end
		end else begin
			if (fc != 0 && fc < p_reg) begin
				lhs = mulm(powm(h_reg, fc, p_reg), powm(fc, sc, p_reg), p_reg);
				res.ver = (lhs == powm(g_reg, msg, p_reg));
			end
		end
		return res;
	endfunction

	function void note_transfer(logic [1:0] fn, u64_t msg, u64_t fc, u64_t sc, u64_t k);
		expected_q = {expected_q, predict(fn, msg, fc, sc, k)};
	endfunction

	function void check_result(egm_pkg::egm_result_t got);
		egm_pkg::egm_result_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h/%h ver=%0d st=%0d",
					got.first, got.second, got.ver, got.st);
			return;
		end
		want = expected_q.pop_front();
		if (got != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %h/%h ver=%0d st=%0d, got %h/%h ver=%0d st=%0d",
					want.first, want.second, want.ver, want.st,
					got.first, got.second, got.ver, got.st);
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import egm_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] message;
	logic [31:0] first_cipher;
	logic [31:0] second_cipher;
	logic [31:0] nonce;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_first;
	logic [31:0] result_second;
	logic        verified;
	logic [1:0]  status;

	elgamal_scoreboard sb;
	longint cycles;
	int items_sent;
	bit hold_results;  // request one long receiver hold-off
	bit quiet;         // no gaps on either side while set

	elgamal_mod_prime_engine u_dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Run limit: a hang anywhere ends the run as a failure.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: check every transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{result_first, result_second, verified, status});
	end

	// Receiver stall pattern: mostly ready, short and long stalls, one long hold-off.
	initial begin
		int pick;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			pick = $urandom_range(0, 99);
			if (hold_results) begin
				hold_results = 0;
				out_stall <= 1'b1;
				repeat (20000) @(posedge clk);
			end else if (quiet || pick < 60) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (pick < 92 ? $urandom_range(1, 3) : $urandom_range(50, 400))
					@(posedge clk);
			end
		end
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55)
			return 0;
		return (pick < 92) ? $urandom_range(1, 4) : $urandom_range(40, 300);
	endfunction

	// One input transfer; called and returns at a rising edge.
	task automatic send_item(logic [1:0] fn, logic [31:0] msg, logic [31:0] fc,
		logic [31:0] sc, logic [31:0] k);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= fn;
		message       <= msg;
		first_cipher  <= fc;
		second_cipher <= sc;
		nonce         <= k;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(fn, msg, fc, sc, k);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// One write cycle, then the write enable drops before the next write.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Load a key set; h is derived as g^x mod p.
	task automatic load_keys(logic [31:0] p, logic [31:0] g, logic [31:0] x);
		write_reg(CFG_MODULUS, p);
		write_reg(CFG_GENERATOR, g);
		write_reg(CFG_PRIV_KEY, x);
		write_reg(CFG_PUB_KEY, 32'(sb.powm(g, x, p)));
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0:       return 32'($urandom_range(0, 40));
			1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_nonce();
		logic [31:0] k;
		k = rand_word();
		return (k == 0) ? 32'd1 : k;
	endfunction

	// Mostly matched pairs (encrypt then decrypt, sign then verify), some noise.
	task automatic random_traffic(int n);
		egm_result_t pre;
		logic [31:0] m, k;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			m = rand_word();
			k = rand_nonce();
			if (pick < 35) begin
				pre = sb.predict(FUNC_ENC, m, 0, 0, k);
				send_item(FUNC_ENC, m, $urandom, $urandom, k);
				send_item(FUNC_DEC, $urandom, pre.first, pre.second, $urandom);
				i++;
			end else if (pick < 70) begin
				pre = sb.predict(FUNC_SIGN, m, 0, 0, k);
				send_item(FUNC_SIGN, m, $urandom, $urandom, k);
				// a quarter of the verifies use a tampered message
				send_item(FUNC_VER, ($urandom_range(0, 3) == 0) ? m ^ 32'h1 : m,
					pre.first, pre.second, $urandom);
				i++;
			end else begin
				send_item(2'($urandom_range(0, 3)), m, rand_word(), rand_word(), k);
			end
		end
	endtask

	initial begin
		egm_result_t pre;
		logic [31:0] p;
		sb = new();
		items_sent = 0;
		hold_results = 0;
		quiet = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODULUS;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_ENC;
		message = '0;
		first_cipher = '0;
		second_cipher = '0;
		nonce = 32'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset keys (h = 0): one of each operation.
		send_item(FUNC_ENC, 32'd7, 0, 0, 32'd3);
		send_item(FUNC_DEC, 0, 32'd5, 32'd9, 1);
		send_item(FUNC_SIGN, 32'd11, 0, 0, 32'd3);
		send_item(FUNC_VER, 32'd11, 32'd8, 32'd1, 1);
		drain();

		// Directed on a large prime: extremes and each special case.
		load_keys(32'd4294967291, 32'd5, 32'hFFFF_FFFF);
		send_item(FUNC_ENC, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
		send_item(FUNC_ENC, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		pre = sb.predict(FUNC_ENC, 32'd123456, 0, 0, 32'd99991);
		send_item(FUNC_ENC, 32'd123456, 0, 0, 32'd99991);
		send_item(FUNC_DEC, 0, pre.first, pre.second, 1);
		send_item(FUNC_DEC, 0, 32'd0, 32'd5, 1);            // c1 zero
		send_item(FUNC_DEC, 0, 32'd4294967291, 32'd5, 1);   // c1 equal to p
		send_item(FUNC_DEC, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_item(FUNC_SIGN, 32'd77, 0, 0, 32'd4);          // even nonce, shares factor
		send_item(FUNC_SIGN, 32'd77, 0, 0, 32'd1);
		pre = sb.predict(FUNC_SIGN, 32'hFFFF_FFFF, 0, 0, 32'd7);
		send_item(FUNC_SIGN, 32'hFFFF_FFFF, 0, 0, 32'd7);
		send_item(FUNC_VER, 32'hFFFF_FFFF, pre.first, pre.second, 1);
		send_item(FUNC_VER, 32'hFFFF_FFFE, pre.first, pre.second, 1);
		send_item(FUNC_VER, 32'd5, 32'd0, 32'd3, 1);        // r zero
		send_item(FUNC_VER, 32'd5, 32'd4294967291, 32'd3, 1); // r equal to p
		send_item(FUNC_VER, 32'd5, 32'hFFFF_FFFF, 32'd0, 1);
		drain();

		// Receiver holds off while items keep coming, then gapless traffic.
		hold_results = 1;
		random_traffic(6);
		drain();
		quiet = 1;
		random_traffic(6);
		quiet = 0;
		drain();

		// Small modulus p = 5; x = 0 and g = 0 edge values.
		load_keys(32'd5, 32'd2, 32'd3);
		random_traffic(20);
		send_item(FUNC_ENC, 32'd9, 0, 0, 32'd2);
		drain();
		write_reg(CFG_GENERATOR, 32'd0);
		write_reg(CFG_PRIV_KEY, 32'd0);
		random_traffic(6);
		drain();

		// Widest non-prime modulus, all-ones generator.
		load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001);
		random_traffic(20);
		drain();

		// Random odd modulus with random keys.
		p = $urandom | 32'h8000_0001;
		load_keys(p, 32'($urandom_range(2, 1000)), $urandom);
		random_traffic(20);
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d items sent over five key sets, %0d results checked, %0d mismatches",
			items_sent, sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0 && sb.results_seen == items_sent)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/egm_pkg.sv
rtl/core/egm_alu.sv
rtl/core/egm_seq.sv
rtl/core/elgamal_mod_prime_engine.sv
rtl/core/egm_chk.sv
test/testbench.sv
